// ===== design/cvgm_pkg.sv =====
`timescale 1ns / 1ps

package cvgm_pkg;

  localparam int CHIP_COUNT_DEF  = 6;
  localparam int GROUP_COUNT_DEF = 6;

  localparam int CELL_W  = 16;
  localparam int MASK_W  = 17;
  localparam int CHIP_W  = 3;
  localparam int GROUP_W = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [GROUP_W-1:0] LAST_GROUP = 3'd5;
  localparam logic [CELL_W-1:0]  ALL_ONES   = 16'hFFFF;

  localparam logic [14:0] CRC_POLY = 15'h4599;
  localparam logic [14:0] CRC_SEED = 15'd16;

  localparam logic [CELL_W-1:0] OV_RESET     = 16'd42000;
  localparam logic [CELL_W-1:0] UV_RESET     = 16'd25000;
  localparam logic [CELL_W-1:0] MARGIN_RESET = 16'd50;

  localparam logic [CFG_IDX_W-1:0] CFG_OV     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UV     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = 2'd2;

  typedef struct packed {
    logic               sos;
    logic               eos;
    logic [CHIP_W-1:0]  chip;
    logic [GROUP_W-1:0] group;
    logic [CELL_W-1:0]  cell_a;
    logic [CELL_W-1:0]  cell_b;
    logic [CELL_W-1:0]  cell_c;
    logic [CELL_W-1:0]  rx_check;
  } item_t;

  typedef struct packed {
    logic [CELL_W-1:0] ov_thr;
    logic [CELL_W-1:0] uv_thr;
    logic [CELL_W-1:0] margin;
  } cfg_t;

  typedef struct packed {
    logic              chip_missing;
    logic              any_missing;
    logic              check_error;
    logic [CELL_W-1:0] err_count;
    logic [CELL_W-1:0] pack_sum;
    logic [CELL_W-1:0] lowest;
    logic [CELL_W-1:0] ov_count;
    logic [CELL_W-1:0] uv_count;
    logic [MASK_W-1:0] mask;
  } res_t;

  // one byte through the crc-15 shift register, msb first
  function automatic logic [14:0] crc15_byte(logic [14:0] rem_in, logic [7:0] data);
    logic [14:0] rem;
    logic        fb;
    rem = rem_in;
    for (int b = 7; b >= 0; b--) begin
      fb  = rem[14] ^ data[b];
      rem = {rem[13:0], 1'b0};
      if (fb) begin
        rem = rem ^ CRC_POLY;
      end
    end
    return rem;
  endfunction

endpackage

// ===== design/cvgm_crc.sv =====
`timescale 1ns / 1ps

module cvgm_crc (
  input  cvgm_pkg::item_t item,
  output logic            crc_err
);

  logic [7:0]  bytes [6];
  logic [14:0] rem   [7];

  always_comb begin
    bytes[0] = item.cell_a[7:0];
    bytes[1] = item.cell_a[15:8];
    bytes[2] = item.cell_b[7:0];
    bytes[3] = item.cell_b[15:8];
    bytes[4] = item.cell_c[7:0];
    bytes[5] = item.cell_c[15:8];
  end

  assign rem[0] = cvgm_pkg::CRC_SEED;

  for (genvar i = 0; i < 6; i++) begin : g_byte
    assign rem[i+1] = cvgm_pkg::crc15_byte(rem[i], bytes[i]);
  end

  assign crc_err = {rem[6], 1'b0} != item.rx_check;

endmodule

// ===== design/cvgm_scan.sv =====
`timescale 1ns / 1ps

module cvgm_scan #(
  parameter int CHIP_COUNT  = cvgm_pkg::CHIP_COUNT_DEF,
  parameter int GROUP_COUNT = cvgm_pkg::GROUP_COUNT_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            upd,
  input  cvgm_pkg::item_t item,
  input  cvgm_pkg::cfg_t  cfg,
  input  logic            crc_err,
  output cvgm_pkg::res_t  res
);

  localparam int CW = cvgm_pkg::CELL_W;
  localparam int MW = cvgm_pkg::MASK_W;

  logic [CW-1:0]         scan_min_r, scan_min_nxt;
  logic [CW-1:0]         prev_min_r, prev_min_nxt;
  logic [MW-1:0]         mask_r   [CHIP_COUNT];
  logic [MW-1:0]         mask_nxt [CHIP_COUNT];
  logic [CHIP_COUNT-1:0] missing_r, missing_nxt;
  logic [CW-1:0]         pack_r, pack_nxt;
  logic [CW-1:0]         ov_r, ov_nxt;
  logic [CW-1:0]         uv_r, uv_nxt;
  logic [CW-1:0]         err_r, err_nxt;

  logic [CW-1:0]  min_base, min_ab, min_b;
  logic [CW:0]    limit;
  logic           hi_a, hi_b, hi_c;
  logic           last_grp;
  logic [MW-1:0]  newbits;
  logic [MW-1:0]  mask_out;
  logic           missing;
  logic [9:0]     add_sum;
  logic [CW-1:0]  pack_base;
  logic [1:0]     ov_n, uv_n;
  logic [CW+1:0]  ov_sum, uv_sum;
  logic [CW-1:0]  ov_base, uv_base;
  logic           ov_a, ov_b, ov_c, uv_a, uv_b, uv_c;

  always_comb begin
    last_grp = item.group == cvgm_pkg::LAST_GROUP;

    // running minimum, last cell of the last group excluded
    min_base = item.sos ? cvgm_pkg::ALL_ONES : scan_min_r;
    min_ab   = (item.cell_a < min_base) ? item.cell_a : min_base;
    min_b    = (item.cell_b < min_ab) ? item.cell_b : min_ab;
    scan_min_nxt = (!last_grp && (item.cell_c < min_b)) ? item.cell_c : min_b;
    prev_min_nxt = item.eos ? scan_min_nxt : prev_min_r;

    // balance request bits
    limit = {1'b0, prev_min_r} + {1'b0, cfg.margin};
    hi_a  = {1'b0, item.cell_a} > limit;
    hi_b  = {1'b0, item.cell_b} > limit;
    hi_c  = {1'b0, item.cell_c} > limit;
    newbits = '0;
    for (int g = 0; g < GROUP_COUNT; g++) begin
      if (32'(item.group) == g) begin
        newbits[3*g] = hi_a;
        if (g == 5) begin
          newbits[16] = hi_b;
        end else begin
          newbits[3*g+1] = hi_b;
          newbits[3*g+2] = hi_c;
        end
      end
    end

    missing = (item.cell_a == cvgm_pkg::ALL_ONES) && (item.cell_b == cvgm_pkg::ALL_ONES)
              && (item.cell_c == cvgm_pkg::ALL_ONES);

    mask_out = '0;
    for (int i = 0; i < CHIP_COUNT; i++) begin
      mask_nxt[i]    = item.sos ? '0 : mask_r[i];
      missing_nxt[i] = missing_r[i];
      if (32'(item.chip) == i) begin
        mask_nxt[i]    = mask_nxt[i] | newbits;
        mask_out       = mask_nxt[i];
        missing_nxt[i] = missing;
      end
    end

    // pack sum, wrapping
    pack_base = item.sos ? '0 : pack_r;
    add_sum   = 10'(item.cell_a[15:8]) + 10'(item.cell_b[15:8]) + 10'(item.cell_c[15:8]);
    pack_nxt  = missing ? pack_base : pack_base + CW'(add_sum);

    // limit counts, saturating
    ov_a = item.cell_a >= cfg.ov_thr;
    ov_b = item.cell_b >= cfg.ov_thr;
    ov_c = item.cell_c >= cfg.ov_thr;
    uv_a = !ov_a && (item.cell_a <= cfg.uv_thr);
    uv_b = !ov_b && (item.cell_b <= cfg.uv_thr);
    uv_c = !ov_c && (item.cell_c <= cfg.uv_thr);
    ov_n = 2'(ov_a) + 2'(ov_b) + 2'(ov_c);
    uv_n = 2'(uv_a) + 2'(uv_b) + 2'(uv_c);
    ov_base = item.sos ? '0 : ov_r;
    uv_base = item.sos ? '0 : uv_r;
    ov_sum  = (CW+2)'(ov_base) + (CW+2)'(ov_n);
    uv_sum  = (CW+2)'(uv_base) + (CW+2)'(uv_n);
    ov_nxt  = (ov_sum[CW+1:CW] != 2'd0) ? cvgm_pkg::ALL_ONES : ov_sum[CW-1:0];
    uv_nxt  = (uv_sum[CW+1:CW] != 2'd0) ? cvgm_pkg::ALL_ONES : uv_sum[CW-1:0];

    err_nxt = (crc_err && (err_r != cvgm_pkg::ALL_ONES)) ? err_r + 1'b1 : err_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_min_r <= cvgm_pkg::ALL_ONES;
      prev_min_r <= cvgm_pkg::ALL_ONES;
      missing_r  <= '0;
      pack_r     <= '0;
      ov_r       <= '0;
      uv_r       <= '0;
      err_r      <= '0;
      for (int i = 0; i < CHIP_COUNT; i++) begin
        mask_r[i] <= '0;
      end
    end else if (upd) begin
      scan_min_r <= scan_min_nxt;
      prev_min_r <= prev_min_nxt;
      missing_r  <= missing_nxt;
      pack_r     <= pack_nxt;
      ov_r       <= ov_nxt;
      uv_r       <= uv_nxt;
      err_r      <= err_nxt;
      for (int i = 0; i < CHIP_COUNT; i++) begin
        mask_r[i] <= mask_nxt[i];
      end
    end
  end

  always_comb begin
    res.chip_missing = missing;
    res.any_missing  = missing_nxt != '0;
    res.check_error  = crc_err;
    res.err_count    = err_nxt;
    res.pack_sum     = pack_nxt;
    res.lowest       = scan_min_nxt;
    res.ov_count     = ov_nxt;
    res.uv_count     = uv_nxt;
    res.mask         = mask_out;
  end

endmodule

// ===== design/cell_voltage_group_monitor_unit.sv =====
`timescale 1ns / 1ps

// Cell voltage group monitor. Each input word is one register group read from one chip:
// three cell codes and the received CRC-15 check word. The block takes one word per
// cycle while the output side is ready and returns one result word per input word. A
// word is held in an input register; the CRC check, limit counts, scan minimum and
// balance mask update are one pass of logic from there into the result register, and
// the scan state is updated on that same edge, so the next word sees it at once.
// Threshold and margin registers are written through the cfg_ port; the user must do
// so only while the block is idle, which is not enforced; no clearing pass after reset.
module cell_voltage_group_monitor_unit #(
  parameter int CHIP_COUNT  = cvgm_pkg::CHIP_COUNT_DEF,
  parameter int GROUP_COUNT = cvgm_pkg::GROUP_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_start_of_scan,
  input  logic        in_end_of_scan,
  input  logic [2:0]  in_chip_index,
  input  logic [2:0]  in_group_index,
  input  logic [15:0] in_cell_a,
  input  logic [15:0] in_cell_b,
  input  logic [15:0] in_cell_c,
  input  logic [15:0] in_received_check,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_chip_missing,
  output logic        out_any_chip_missing,
  output logic        out_check_error,
  output logic [15:0] out_check_error_count,
  output logic [15:0] out_pack_sum,
  output logic [15:0] out_lowest_cell,
  output logic [15:0] out_overvoltage_count,
  output logic [15:0] out_undervoltage_count,
  output logic [16:0] out_balance_mask
);

  cvgm_pkg::cfg_t  cfg_r;
  cvgm_pkg::item_t item_r;
  cvgm_pkg::res_t  res_r;
  cvgm_pkg::res_t  res;
  logic            s1_valid_r;
  logic            out_valid_r;
  logic            advance;
  logic            crc_err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ov_thr <= cvgm_pkg::OV_RESET;
      cfg_r.uv_thr <= cvgm_pkg::UV_RESET;
      cfg_r.margin <= cvgm_pkg::MARGIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        cvgm_pkg::CFG_OV:     cfg_r.ov_thr <= cfg_wdata;
        cvgm_pkg::CFG_UV:     cfg_r.uv_thr <= cfg_wdata;
        cvgm_pkg::CFG_MARGIN: cfg_r.margin <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.sos      <= in_start_of_scan;
      item_r.eos      <= in_end_of_scan;
      item_r.chip     <= in_chip_index;
      item_r.group    <= in_group_index;
      item_r.cell_a   <= in_cell_a;
      item_r.cell_b   <= in_cell_b;
      item_r.cell_c   <= in_cell_c;
      item_r.rx_check <= in_received_check;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  cvgm_crc u_crc (
    .item    (item_r),
    .crc_err (crc_err)
  );

  cvgm_scan #(
    .CHIP_COUNT  (CHIP_COUNT),
    .GROUP_COUNT (GROUP_COUNT)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (advance),
    .item    (item_r),
    .cfg     (cfg_r),
    .crc_err (crc_err),
    .res     (res)
  );

  assign out_valid              = out_valid_r;
  assign out_chip_missing       = res_r.chip_missing;
  assign out_any_chip_missing   = res_r.any_missing;
  assign out_check_error        = res_r.check_error;
  assign out_check_error_count  = res_r.err_count;
  assign out_pack_sum           = res_r.pack_sum;
  assign out_lowest_cell        = res_r.lowest;
  assign out_overvoltage_count  = res_r.ov_count;
  assign out_undervoltage_count = res_r.uv_count;
  assign out_balance_mask       = res_r.mask;

`ifndef SYNTHESIS
  a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("input taken while both stages are full");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("word left input stage without reaching output");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r)
    else $error("held word dropped from input stage");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int STALL_LIMIT = 2000;
  localparam int SHOWN_LIMIT = 40;

  logic                                 clk;
  logic                                 rst_n = 1'b0;
  logic                                 cfg_we = 1'b0;
  logic [cvgm_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [cvgm_pkg::CELL_W-1:0]          cfg_wdata = '0;
  logic                                 in_valid = 1'b0;
  logic                                 in_ready;
  logic                                 in_start_of_scan = 1'b0;
  logic                                 in_end_of_scan = 1'b0;
  logic [cvgm_pkg::CHIP_W-1:0]          in_chip_index = '0;
  logic [cvgm_pkg::GROUP_W-1:0]         in_group_index = '0;
  logic [cvgm_pkg::CELL_W-1:0]          in_cell_a = '0;
  logic [cvgm_pkg::CELL_W-1:0]          in_cell_b = '0;
  logic [cvgm_pkg::CELL_W-1:0]          in_cell_c = '0;
  logic [cvgm_pkg::CELL_W-1:0]          in_received_check = '0;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic                                 out_chip_missing;
  logic                                 out_any_chip_missing;
  logic                                 out_check_error;
  logic [cvgm_pkg::CELL_W-1:0]          out_check_error_count;
  logic [cvgm_pkg::CELL_W-1:0]          out_pack_sum;
  logic [cvgm_pkg::CELL_W-1:0]          out_lowest_cell;
  logic [cvgm_pkg::CELL_W-1:0]          out_overvoltage_count;
  logic [cvgm_pkg::CELL_W-1:0]          out_undervoltage_count;
  logic [cvgm_pkg::MASK_W-1:0]          out_balance_mask;

  cell_voltage_group_monitor_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_start_of_scan(in_start_of_scan),
    .in_end_of_scan(in_end_of_scan),
    .in_chip_index(in_chip_index),
    .in_group_index(in_group_index),
    .in_cell_a(in_cell_a),
    .in_cell_b(in_cell_b),
    .in_cell_c(in_cell_c),
    .in_received_check(in_received_check),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_chip_missing(out_chip_missing),
    .out_any_chip_missing(out_any_chip_missing),
    .out_check_error(out_check_error),
    .out_check_error_count(out_check_error_count),
    .out_pack_sum(out_pack_sum),
    .out_lowest_cell(out_lowest_cell),
    .out_overvoltage_count(out_overvoltage_count),
    .out_undervoltage_count(out_undervoltage_count),
    .out_balance_mask(out_balance_mask)
  );

  // monitor model state
  logic [cvgm_pkg::CELL_W-1:0] cfg_ov = cvgm_pkg::OV_RESET;
  logic [cvgm_pkg::CELL_W-1:0] cfg_uv = cvgm_pkg::UV_RESET;
  logic [cvgm_pkg::CELL_W-1:0] cfg_margin = cvgm_pkg::MARGIN_RESET;
  logic [cvgm_pkg::CELL_W-1:0] scan_min = cvgm_pkg::ALL_ONES;
  logic [cvgm_pkg::CELL_W-1:0] prev_min = cvgm_pkg::ALL_ONES;
  logic [cvgm_pkg::MASK_W-1:0] chip_masks [cvgm_pkg::CHIP_COUNT_DEF];
  logic [cvgm_pkg::CHIP_COUNT_DEF-1:0] missing_chips = '0;
  logic [cvgm_pkg::CELL_W-1:0] pack_acc = '0;
  logic [cvgm_pkg::CELL_W-1:0] over_cnt = '0;
  logic [cvgm_pkg::CELL_W-1:0] under_cnt = '0;
  logic [cvgm_pkg::CELL_W-1:0] err_cnt = '0;

  cvgm_pkg::res_t expected_status [$];
  cvgm_pkg::item_t seen_reading;
  cvgm_pkg::res_t want_status;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int failures = 0;
  int stall_cycles = 0;
  int readings_sent = 0;
  int status_checked = 0;
  int scans_run = 0;
  int config_sets = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    foreach (chip_masks[i]) chip_masks[i] = '0;
  end

  function automatic logic [15:0] crc15_of_cells(logic [15:0] a, logic [15:0] b,
                                                 logic [15:0] c);
    logic [47:0] stream;
    logic [14:0] rem;
    logic        fb;
    stream = {a[7:0], a[15:8], b[7:0], b[15:8], c[7:0], c[15:8]};
    rem = cvgm_pkg::CRC_SEED;
    for (int i = 47; i >= 0; i--) begin
      fb  = rem[14] ^ stream[i];
      rem = {rem[13:0], 1'b0} ^ (fb ? cvgm_pkg::CRC_POLY : 15'd0);
    end
    return {rem, 1'b0};
  endfunction

  function automatic cvgm_pkg::res_t predict_status(cvgm_pkg::item_t it);
    cvgm_pkg::res_t              r;
    logic [cvgm_pkg::CELL_W-1:0] cells [3];
    logic [16:0]                 limit;
    logic [cvgm_pkg::MASK_W-1:0] newbits;
    logic                        chip_ok;
    logic                        group_ok;
    logic                        missing;
    int                          pos;
    cells[0] = it.cell_a;
    cells[1] = it.cell_b;
    cells[2] = it.cell_c;
    chip_ok  = it.chip < cvgm_pkg::CHIP_COUNT_DEF;
    group_ok = it.group < cvgm_pkg::GROUP_COUNT_DEF;
    if (it.sos) begin
      pack_acc  = '0;
      over_cnt  = '0;
      under_cnt = '0;
      foreach (chip_masks[i]) chip_masks[i] = '0;
      scan_min = cvgm_pkg::ALL_ONES;
    end
    limit   = {1'b0, prev_min} + {1'b0, cfg_margin};
    newbits = '0;
    for (int k = 0; k < 3; k++) begin
      if (!(k == 2 && it.group == cvgm_pkg::LAST_GROUP)) begin
        if (cells[k] < scan_min) scan_min = cells[k];
        if ({1'b0, cells[k]} > limit && group_ok) begin
          pos = (k == 1 && it.group == cvgm_pkg::LAST_GROUP) ? 16 : it.group * 3 + k;
          newbits[pos] = 1'b1;
        end
      end
    end
    missing = cells[0] == cvgm_pkg::ALL_ONES && cells[1] == cvgm_pkg::ALL_ONES
              && cells[2] == cvgm_pkg::ALL_ONES;
    r.mask = '0;
    if (chip_ok) begin
      chip_masks[it.chip] = chip_masks[it.chip] | newbits;
      r.mask = chip_masks[it.chip];
      missing_chips[it.chip] = missing;
    end
    if (!missing) pack_acc = pack_acc + (cells[0] >> 8) + (cells[1] >> 8) + (cells[2] >> 8);
    for (int k = 0; k < 3; k++) begin
      if (cells[k] >= cfg_ov) begin
        if (over_cnt != cvgm_pkg::ALL_ONES) over_cnt++;
      end else if (cells[k] <= cfg_uv) begin
        if (under_cnt != cvgm_pkg::ALL_ONES) under_cnt++;
      end
    end
    r.check_error = crc15_of_cells(cells[0], cells[1], cells[2]) != it.rx_check;
    if (r.check_error && err_cnt != cvgm_pkg::ALL_ONES) err_cnt++;
    if (it.eos) prev_min = scan_min;
    r.chip_missing = missing;
    r.any_missing  = |missing_chips;
    r.err_count    = err_cnt;
    r.pack_sum     = pack_acc;
    r.lowest       = scan_min;
    r.ov_count     = over_cnt;
    r.uv_count     = under_cnt;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [16:0] want, input logic [16:0] got);
    if (want !== got) begin
      failures++;
      if (failures <= SHOWN_LIMIT) begin
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      seen_reading.sos      = in_start_of_scan;
      seen_reading.eos      = in_end_of_scan;
      seen_reading.chip     = in_chip_index;
      seen_reading.group    = in_group_index;
      seen_reading.cell_a   = in_cell_a;
      seen_reading.cell_b   = in_cell_b;
      seen_reading.cell_c   = in_cell_c;
      seen_reading.rx_check = in_received_check;
      expected_status.push_back(predict_status(seen_reading));
      readings_sent++;
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_status.size() == 0) begin
        failures++;
        if (failures <= SHOWN_LIMIT) begin
          $display("%0t: status word with no reading pending", $time);
        end
      end else begin
        want_status = expected_status.pop_front();
        status_checked++;
        check_field("chip_missing", want_status.chip_missing, out_chip_missing);
        check_field("any_chip_missing", want_status.any_missing, out_any_chip_missing);
        check_field("check_error", want_status.check_error, out_check_error);
        check_field("check_error_count", want_status.err_count, out_check_error_count);
        check_field("pack_sum", want_status.pack_sum, out_pack_sum);
        check_field("lowest_cell", want_status.lowest, out_lowest_cell);
        check_field("overvoltage_count", want_status.ov_count, out_overvoltage_count);
        check_field("undervoltage_count", want_status.uv_count, out_undervoltage_count);
        check_field("balance_mask", want_status.mask, out_balance_mask);
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic cvgm_pkg::item_t make_reading(logic sos, logic eos, logic [2:0] chip,
                                                   logic [2:0] group, logic [15:0] a,
                                                   logic [15:0] b, logic [15:0] c,
                                                   logic bad);
    cvgm_pkg::item_t it;
    logic [15:0]     good;
    good        = crc15_of_cells(a, b, c);
    it.sos      = sos;
    it.eos      = eos;
    it.chip     = chip;
    it.group    = group;
    it.cell_a   = a;
    it.cell_b   = b;
    it.cell_c   = c;
    it.rx_check = bad ? good ^ 16'($urandom_range(1, 65535)) : good;
    return it;
  endfunction

  function automatic logic [15:0] rand_code();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(5))
          0: return 16'd0;
          1: return cvgm_pkg::ALL_ONES;
          2: return cfg_ov;
          3: return cfg_ov - 16'd1;
          4: return cfg_uv;
          default: return cfg_uv + 16'd1;
        endcase
      end
      1: return 16'($urandom());
      default: return 16'($urandom_range(cfg_ov, cfg_uv));
    endcase
  endfunction

  task automatic send_reading(input cvgm_pkg::item_t it);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid          <= 1'b1;
    in_start_of_scan  <= it.sos;
    in_end_of_scan    <= it.eos;
    in_chip_index     <= it.chip;
    in_group_index    <= it.group;
    in_cell_a         <= it.cell_a;
    in_cell_b         <= it.cell_b;
    in_cell_c         <= it.cell_c;
    in_received_check <= it.rx_check;
    do @(posedge clk); while (!in_ready);
  endtask

  // wait for every pending status word, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [cvgm_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      cvgm_pkg::CFG_OV: cfg_ov = val;
      cvgm_pkg::CFG_UV: cfg_uv = val;
      default: cfg_margin = val;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [15:0] ov, input logic [15:0] uv,
                              input logic [15:0] margin);
    settle();
    write_reg(cvgm_pkg::CFG_OV, ov);
    write_reg(cvgm_pkg::CFG_UV, uv);
    write_reg(cvgm_pkg::CFG_MARGIN, margin);
    config_sets++;
  endtask

  task automatic run_scan();
    int          lo;
    int          hi;
    int          gone;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    if ($urandom_range(1)) begin
      lo = 0;
      hi = cvgm_pkg::CHIP_COUNT_DEF - 1;
    end else begin
      lo = $urandom_range(cvgm_pkg::CHIP_COUNT_DEF - 1);
      hi = $urandom_range(cvgm_pkg::CHIP_COUNT_DEF - 1, lo);
    end
    gone = ($urandom_range(9) == 0) ? $urandom_range(hi, lo) : -1;
    for (int chip = lo; chip <= hi; chip++) begin
      for (int g = 0; g < cvgm_pkg::GROUP_COUNT_DEF; g++) begin
        if ($urandom_range(24) == 0) begin
          send_reading(make_reading($urandom_range(9) == 0, $urandom_range(9) == 0,
                                    3'($urandom_range(7)), 3'($urandom_range(7)),
                                    16'($urandom()), 16'($urandom()), 16'($urandom()),
                                    1'($urandom_range(1))));
        end
        if (chip == gone) begin
          a = cvgm_pkg::ALL_ONES;
          b = cvgm_pkg::ALL_ONES;
          c = cvgm_pkg::ALL_ONES;
        end else begin
          a = rand_code();
          b = rand_code();
          c = rand_code();
        end
        send_reading(make_reading(chip == lo && g == 0,
                                  chip == hi && g == cvgm_pkg::GROUP_COUNT_DEF - 1,
                                  3'(chip), 3'(g), a, b, c, $urandom_range(9) == 0));
      end
    end
    scans_run++;
  endtask

  task automatic test_directed_readings();
    cvgm_pkg::item_t it;
    send_reading(make_reading(1, 0, 0, 0, 16'd0, 16'd0, 16'd0, 0));
    send_reading(make_reading(0, 0, 0, 1, cvgm_pkg::ALL_ONES, cvgm_pkg::ALL_ONES,
                              cvgm_pkg::ALL_ONES, 0));
    send_reading(make_reading(0, 0, 0, 1, 16'd42000, 16'd41999, 16'd25000, 0));
    send_reading(make_reading(0, 0, 0, 2, 16'd25001, 16'd65534, 16'd1, 1));
    send_reading(make_reading(0, 0, 6, 0, cvgm_pkg::ALL_ONES, cvgm_pkg::ALL_ONES,
                              cvgm_pkg::ALL_ONES, 0));
    send_reading(make_reading(0, 0, 7, 7, 16'd30000, 16'd30000, 16'd30000, 0));
    send_reading(make_reading(0, 0, 1, 6, 16'd50000, 16'd50000, 16'd50000, 0));
    send_reading(make_reading(0, 1, 1, 5, 16'd40000, 16'd40000, 16'd0, 0));
    for (int g = 0; g < cvgm_pkg::GROUP_COUNT_DEF; g++) begin
      send_reading(make_reading(g == 0, g == cvgm_pkg::GROUP_COUNT_DEF - 1, 2, 3'(g),
                                16'd40000, 16'd40001, 16'd40002, 0));
    end
    it = make_reading(1, 0, 3, 3, 16'h1234, 16'h8000, 16'h00FF, 0);
    it.rx_check = 16'h0000;
    send_reading(it);
    it = make_reading(0, 0, 3, 4, 16'hAAAA, 16'h5555, 16'h0F0F, 0);
    it.rx_check = cvgm_pkg::ALL_ONES;
    send_reading(it);
    send_reading(make_reading(1, 1, 4, 4, 16'd30000, 16'd20000, 16'd45000, 0));
    send_reading(make_reading(0, 0, 5, 5, cvgm_pkg::ALL_ONES, cvgm_pkg::ALL_ONES,
                              16'd100, 0));
    send_reading(make_reading(0, 1, 5, 5, 16'd100, 16'd200, cvgm_pkg::ALL_ONES, 1));
    scans_run += 4;
  endtask

  task automatic test_threshold_extremes();
    apply_config(16'd0, cvgm_pkg::ALL_ONES, 16'd0);
    run_scan();
    apply_config(cvgm_pkg::ALL_ONES, 16'd0, cvgm_pkg::ALL_ONES);
    run_scan();
    apply_config(16'd1, 16'd65534, 16'd1);
    run_scan();
  endtask

  task automatic test_idle_phase(input int send_pct, input int recv_pct);
    apply_config(16'($urandom_range(38000, 45000)), 16'($urandom_range(22000, 30000)),
                 16'($urandom_range(400)));
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int s = 0; s < 4; s++) begin
      run_scan();
      if (s == 1) settle();
    end
  endtask

  // run with start of scan on the first reading only, so the counts keep growing across chips and groups
  task automatic test_counter_growth();
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    apply_config(16'd40000, 16'd20000, 16'd0);
    for (int i = 0; i < 24; i++) begin
      if (i < 8) begin
        a = 16'($urandom_range(50000, 65534));
        b = 16'($urandom_range(50000, 65534));
        c = 16'($urandom_range(50000, 65534));
      end else if (i < 16) begin
        a = 16'($urandom_range(20000));
        b = 16'($urandom_range(20000));
        c = 16'($urandom_range(20000));
      end else begin
        a = rand_code();
        b = rand_code();
        c = 16'($urandom_range(65534));
      end
      send_reading(make_reading(i == 0, 1'b0, 3'($urandom_range(5)), 3'($urandom_range(5)),
                                a, b, c, 1'b1));
    end
    scans_run++;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_readings();
    test_threshold_extremes();
    test_idle_phase(0, 0);
    test_idle_phase(73, 0);
    test_idle_phase(0, 73);
    test_idle_phase(34, 34);
    test_counter_growth();
    settle();
    repeat (10) @(posedge clk);
    $display("%0d readings over %0d scans, %0d status words compared, %0d threshold sets",
             readings_sent, scans_run, status_checked, config_sets);
    $display("covered sender and receiver stalls, missing chips, bad checks, counts across scans");
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== cell_voltage_group_monitor_unit.f =====
design/cvgm_pkg.sv
design/cvgm_crc.sv
design/cvgm_scan.sv
design/cell_voltage_group_monitor_unit.sv
tb/testbench.sv
